// ===== hdl/mcc_pkg.sv =====
// ----------------------------------------------------------------------------
// mcc_pkg: shared types and microcode tables
// Transaction structs, state struct, control signal bits and the per-opcode
// microcode step lookups of the microcoded CPU control unit.
// ----------------------------------------------------------------------------
package mcc_pkg;

  localparam int unsigned CW_W = 14;
  localparam logic [7:0] LOAD_LIMIT = 8'd255;

  localparam logic [CW_W-1:0] SIG_AOUT   = 14'h0001;
  localparam logic [CW_W-1:0] SIG_AIN    = 14'h0002;
  localparam logic [CW_W-1:0] SIG_BRIN   = 14'h0004;
  localparam logic [CW_W-1:0] SIG_MOUT   = 14'h0008;
  localparam logic [CW_W-1:0] SIG_MIN    = 14'h0010;
  localparam logic [CW_W-1:0] SIG_ARIN   = 14'h0020;
  localparam logic [CW_W-1:0] SIG_REOUT  = 14'h0040;
  localparam logic [CW_W-1:0] SIG_ALUSUB = 14'h0000;
  localparam logic [CW_W-1:0] SIG_ALUADD = 14'h0080;
  localparam logic [CW_W-1:0] SIG_PCOUT  = 14'h0100;
  localparam logic [CW_W-1:0] SIG_PCEN   = 14'h0200;
  localparam logic [CW_W-1:0] SIG_RST    = 14'h0400;
  localparam logic [CW_W-1:0] SIG_IRIN   = 14'h0800;
  localparam logic [CW_W-1:0] SIG_CDOUT  = 14'h1000;
  localparam logic [CW_W-1:0] SIG_OUTIN  = 14'h2000;

  typedef enum logic [3:0] {
    OP_LDI  = 4'd0,
    OP_LDM  = 4'd1,
    OP_ST   = 4'd2,
    OP_ADR  = 4'd3,
    OP_DIR  = 4'd4,
    OP_ADM  = 4'd5,
    OP_SBM  = 4'd6,
    OP_RST  = 4'd7,
    OP_HALT = 4'd8
  } opcode_t;

  typedef struct packed {
    logic       edge_kind;
    logic [7:0] instr_byte;
    logic [7:0] boot_data;
  } mcc_in_t;

  typedef struct packed {
    logic            word_valid;
    logic [CW_W-1:0] control_word;
    logic            data_valid;
    logic [7:0]      control_data;
    logic            pc_reset_pulse;
    logic            is_halted;
  } mcc_out_t;

  typedef struct packed {
    logic       phase_booting;
    logic       phase_resetting;
    logic       phase_fetching;
    logic       halt_flag;
    logic [1:0] step_count;
    logic [7:0] load_index;
    logic       b_edge_seen;
  } mcc_state_t;

  function automatic opcode_t op_decode(input logic [3:0] nib);
    opcode_t op;
    op = (nib > 4'd8) ? OP_HALT : opcode_t'(nib);
    return op;
  endfunction

  function automatic logic [CW_W-1:0] micro_word(input opcode_t op, input logic [1:0] sc);
    logic [CW_W-1:0] w;
    w = '0;
    unique case (op)
      OP_LDI: begin
        if (sc == 2'd0) w = SIG_PCOUT | SIG_ARIN;
        else if (sc == 2'd1) w = SIG_MOUT | SIG_PCEN;
      end
      OP_LDM: begin
        if (sc == 2'd0) w = SIG_PCOUT | SIG_ARIN;
        else if (sc == 2'd1) w = SIG_MOUT | SIG_ARIN | SIG_PCEN;
        else if (sc == 2'd2) w = SIG_MOUT;
      end
      OP_ST: begin
        if (sc == 2'd0) w = SIG_PCOUT | SIG_ARIN;
        else if (sc == 2'd1) w = SIG_MOUT | SIG_ARIN | SIG_PCEN;
        else if (sc == 2'd2) w = SIG_MIN;
      end
      OP_ADR: begin
        if (sc == 2'd0) w = SIG_ALUADD | SIG_REOUT;
      end
      OP_DIR: begin
        if (sc == 2'd0) w = SIG_ALUSUB | SIG_REOUT;
      end
      OP_ADM: begin
        if (sc == 2'd0) w = SIG_PCOUT | SIG_ARIN;
        else if (sc == 2'd1) w = SIG_MOUT | SIG_ARIN | SIG_PCEN;
        else if (sc == 2'd2) w = SIG_ALUADD | SIG_REOUT | SIG_MIN;
      end
      OP_SBM: begin
        if (sc == 2'd0) w = SIG_PCOUT | SIG_ARIN;
        else if (sc == 2'd1) w = SIG_MOUT | SIG_ARIN | SIG_PCEN;
        else if (sc == 2'd2) w = SIG_ALUSUB | SIG_REOUT | SIG_MIN;
      end
      OP_RST: begin
        if (sc == 2'd0) w = SIG_RST;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [1:0] step_total(input opcode_t op);
    logic [1:0] n;
    unique case (op)
      OP_LDI:                       n = 2'd2;
      OP_LDM, OP_ST, OP_ADM, OP_SBM: n = 2'd3;
      default:                      n = 2'd1;
    endcase
    return n;
  endfunction

  function automatic logic [CW_W-1:0] reg_in_bits(input logic [3:0] rg);
    logic [CW_W-1:0] w;
    unique case (rg)
      4'd0:    w = SIG_OUTIN;
      4'd1:    w = SIG_AIN;
      4'd2:    w = SIG_BRIN;
      4'd4:    w = SIG_ARIN;
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [CW_W-1:0] reg_out_bits(input logic [3:0] rg);
    logic [CW_W-1:0] w;
    unique case (rg)
      4'd1:    w = SIG_AOUT;
      4'd3:    w = SIG_REOUT;
      4'd5:    w = SIG_MOUT;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/microcoded_cpu_control_unit.sv =====
// ----------------------------------------------------------------------------
// microcoded_cpu_control_unit: control unit of a small 8-bit microcoded CPU
// Each input transaction is one clock A or B edge with the instruction byte
// and the boot byte. Each accepted transaction yields exactly one result
// transaction: control word, control data, program counter reset pulse and
// halt status, in order.
// The result is registered: out_valid rises in the cycle after input acceptance.
// Throughput: one transaction per cycle; phase and step state update at
// acceptance, and the result sits in an output register, so a new input is
// taken only while the output register is empty or is being drained in the
// same cycle.
// When out_ready is low with a result pending, in_ready drops and all state
// holds until the result is taken.
// Reset (rst_n low, synchronous): enter the memory load phase at load
// index 0, step 0, not halted, no B edge seen, output register empty.
// ----------------------------------------------------------------------------
module microcoded_cpu_control_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mcc_pkg::mcc_in_t    in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mcc_pkg::mcc_out_t   out_data
);

  mcc_pkg::mcc_state_t state_r;
  mcc_pkg::mcc_state_t state_nxt;
  mcc_pkg::mcc_out_t   out_r;
  mcc_pkg::mcc_out_t   out_nxt;
  logic                out_valid_r;
  logic                take;

  assign in_ready  = !out_valid_r || out_ready;
  assign take      = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  mcc_step u_step (
    .st     (state_r),
    .item   (in_data),
    .st_nxt (state_nxt),
    .res    (out_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase_booting   <= 1'b1;
      state_r.phase_resetting <= 1'b1;
      state_r.phase_fetching  <= 1'b1;
      state_r.halt_flag       <= 1'b0;
      state_r.step_count      <= '0;
      state_r.load_index      <= '0;
      state_r.b_edge_seen     <= 1'b0;
      out_valid_r             <= 1'b0;
    end else begin
      if (take) begin
        state_r <= state_nxt;
      end
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_r <= out_nxt;
    end
  end

endmodule

// ===== hdl/mcc_step.sv =====
// ----------------------------------------------------------------------------
// mcc_step: per-edge control logic
// Computes the result and the next phase/step state for one clock edge.
// ----------------------------------------------------------------------------
module mcc_step (
  input  mcc_pkg::mcc_state_t st,
  input  mcc_pkg::mcc_in_t    item,
  output mcc_pkg::mcc_state_t st_nxt,
  output mcc_pkg::mcc_out_t   res
);

  mcc_pkg::opcode_t          op;
  logic [3:0]                rg;
  logic [mcc_pkg::CW_W-1:0]  tab_w;
  logic [mcc_pkg::CW_W-1:0]  ex_w;
  logic [2:0]                sc_inc;
  logic [1:0]                sc_wrap;
  logic                      b_edge;
  logic                      run_edge;

  assign op      = mcc_pkg::op_decode(item.instr_byte[7:4]);
  assign rg      = item.instr_byte[3:0];
  assign tab_w   = mcc_pkg::micro_word(op, st.step_count);
  assign sc_inc  = {1'b0, st.step_count} + 3'd1;
  assign sc_wrap = sc_inc[1:0];
  assign b_edge  = item.edge_kind;
  assign run_edge = b_edge || st.b_edge_seen;

  always_comb begin
    ex_w = tab_w;
    if (st.step_count == 2'd0 && (op == mcc_pkg::OP_ADR || op == mcc_pkg::OP_DIR)) begin
      ex_w = tab_w | mcc_pkg::reg_in_bits(rg);
    end else if (st.step_count == 2'd1 && op == mcc_pkg::OP_LDI) begin
      ex_w = tab_w | mcc_pkg::reg_in_bits(rg);
    end else if (st.step_count == 2'd2 && op == mcc_pkg::OP_LDM) begin
      ex_w = tab_w | mcc_pkg::reg_in_bits(rg);
    end else if (st.step_count == 2'd2 && op == mcc_pkg::OP_ST) begin
      ex_w = tab_w | mcc_pkg::reg_out_bits(rg);
    end
  end

  always_comb begin
    st_nxt = st;
    res    = '0;
    st_nxt.b_edge_seen = b_edge;
    if (run_edge) begin
      priority if (st.phase_booting) begin
        if (b_edge) begin
          if (st.step_count == 2'd0) begin
            res.data_valid   = 1'b1;
            res.control_data = st.load_index;
            res.word_valid   = 1'b1;
            res.control_word = mcc_pkg::SIG_CDOUT | mcc_pkg::SIG_ARIN;
          end else if (st.step_count == 2'd1) begin
            res.data_valid    = 1'b1;
            res.control_data  = item.boot_data;
            res.word_valid    = 1'b1;
            res.control_word  = mcc_pkg::SIG_CDOUT | mcc_pkg::SIG_MIN;
            st_nxt.load_index = st.load_index + 8'd1;
          end
        end else begin
          res.word_valid    = 1'b1;
          st_nxt.step_count = (sc_wrap >= 2'd2) ? 2'd0 : sc_wrap;
          if (st.load_index >= mcc_pkg::LOAD_LIMIT) begin
            st_nxt.load_index      = '0;
            st_nxt.step_count      = '0;
            st_nxt.phase_booting   = 1'b0;
            st_nxt.phase_resetting = 1'b1;
          end
        end
      end else if (st.phase_resetting) begin
        if (b_edge) begin
          res.pc_reset_pulse = 1'b1;
        end else begin
          st_nxt.phase_resetting = 1'b0;
          st_nxt.halt_flag       = 1'b0;
          st_nxt.phase_fetching  = 1'b1;
        end
      end else if (st.halt_flag) begin
        res.word_valid = 1'b1;
      end else if (st.phase_fetching) begin
        if (b_edge) begin
          if (st.step_count == 2'd0) begin
            res.word_valid   = 1'b1;
            res.control_word = mcc_pkg::SIG_PCOUT | mcc_pkg::SIG_ARIN;
          end else if (st.step_count == 2'd1) begin
            res.word_valid   = 1'b1;
            res.control_word = mcc_pkg::SIG_MOUT | mcc_pkg::SIG_IRIN | mcc_pkg::SIG_PCEN;
          end
        end else begin
          res.word_valid    = 1'b1;
          st_nxt.step_count = sc_wrap;
          if (sc_wrap == 2'd2) begin
            st_nxt.step_count     = '0;
            st_nxt.phase_fetching = 1'b0;
          end
        end
      end else begin
        if (b_edge) begin
          res.word_valid   = 1'b1;
          res.control_word = ex_w;
        end else if (sc_inc == {1'b0, mcc_pkg::step_total(op)}) begin
          st_nxt.step_count     = '0;
          st_nxt.phase_fetching = 1'b1;
          if (op == mcc_pkg::OP_HALT) st_nxt.halt_flag = 1'b1;
        end else begin
          res.word_valid    = 1'b1;
          st_nxt.step_count = sc_wrap;
        end
      end
    end
    res.is_halted = st_nxt.halt_flag;
  end

endmodule
